FILE: hw/rtl/sapm_pkg.sv
// ----------------------------------------------------------------------------
// sapm_pkg
// Shared types and constants of the shift-and pattern matcher: item modes,
// field widths, stream packing and the pattern store write request.
// ----------------------------------------------------------------------------
package sapm_pkg;

	// Field widths of one input item and one result item
	localparam int MODE_BITS     = 2;
	localparam int SLOT_BITS     = 6;
	localparam int CHAR_BITS     = 8;
	localparam int LEN_BITS      = 7;
	localparam int OUT_POS_BITS  = 32;

	// Stream widths (packed fields, zero filled to whole bytes)
	localparam int S_TDATA_BITS  = 16;
	localparam int S_TUSER_BITS  = MODE_BITS;
	localparam int M_TDATA_BITS  = 40;

	// Configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;

	// Register index, taken from paddr[2]
	localparam logic REG_PATTERN_LENGTH = 1'b0;

	// Item modes
	localparam logic [MODE_BITS-1:0] MODE_LOAD    = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_TEXT    = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_RESTART = 2'd2;

	// Pattern store write request
	typedef struct packed {
		logic                 en;
		logic [SLOT_BITS-1:0] slot;
		logic [CHAR_BITS-1:0] data;
	} store_wr_t;

endpackage

FILE: hw/rtl/sapm_pattern_store.sv
// ----------------------------------------------------------------------------
// sapm_pattern_store
// Pattern character registers, one per lane, with a comparator in every lane.
// Gives the per-lane match mask for a text byte and the one-hot last lane.
// ----------------------------------------------------------------------------
module sapm_pattern_store #(
	parameter int PATTERN_MAX = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sapm_pkg::store_wr_t                  wr,
	input  logic [sapm_pkg::CHAR_BITS-1:0]       text_byte,
	input  logic [sapm_pkg::LEN_BITS-1:0]        act_len,
	output logic [PATTERN_MAX-1:0]               match_mask,
	output logic [PATTERN_MAX-1:0]               last_lane
);
	import sapm_pkg::*;

	logic [CHAR_BITS-1:0] store_q [PATTERN_MAX];

	// Write one slot; slots beyond the store match no lane and are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				store_q[i] <= '0;
			end
		end else if (wr.en) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (wr.slot == SLOT_BITS'(i)) begin
					store_q[i] <= wr.data;
				end
			end
		end
	end

	// Compare every active lane with the text byte
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			match_mask[i] = (store_q[i] == text_byte) && (LEN_BITS'(i) < act_len);
			last_lane[i]  = (act_len == LEN_BITS'(i + 1));
		end
	end

endmodule

FILE: hw/rtl/shift_and_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// shift_and_pattern_matcher_unit
// Shift-and string matcher over a pattern of up to PATTERN_MAX characters.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle with no bubbles while results are taken. Load
// items write a pattern character, restart items clear the search, and each
// text byte yields one result, presented through the input register, then
// the result register. A result left waiting in the result register holds
// back only a text byte behind it. The rate is set by the update of the
// match vector: all lanes compare the byte, and the shifted vector is ANDed
// with their mask before the next byte. Pattern length is set through the
// register at address 0; values of 0 act as 1 and values above PATTERN_MAX
// act as PATTERN_MAX.
// ----------------------------------------------------------------------------
module shift_and_pattern_matcher_unit #(
	parameter int PATTERN_MAX   = 64,
	parameter int POSITION_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [sapm_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [sapm_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [sapm_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	// Input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [sapm_pkg::S_TDATA_BITS-1:0]   s_tdata,  // pattern_index[5:0], value[13:6]
	input  logic [sapm_pkg::S_TUSER_BITS-1:0]   s_tuser,  // mode[1:0]
	// Result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [sapm_pkg::M_TDATA_BITS-1:0]   m_tdata   // hit[0], start_position[32:1],
	                                                      // first_hit[33]
);
	import sapm_pkg::*;

	localparam logic [PATTERN_MAX-1:0]   VEC_ONE = PATTERN_MAX'(1);
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

	// Configuration register
	logic [LEN_BITS-1:0] len_q;
	logic                cfg_wr;

	// Input register
	logic                 s1_valid;
	logic [MODE_BITS-1:0] s1_mode;
	logic [SLOT_BITS-1:0] s1_slot;
	logic [CHAR_BITS-1:0] s1_value;

	// Search state
	logic [PATTERN_MAX-1:0]   vec_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     found_q;

	// Result register
	logic                    m_valid_q;
	logic                    hit_q;
	logic [OUT_POS_BITS-1:0] start_q;
	logic                    first_q;

	// Datapath
	logic [LEN_BITS-1:0]      act_len;
	logic [PATTERN_MAX-1:0]   match_mask;
	logic [PATTERN_MAX-1:0]   last_lane;
	logic [PATTERN_MAX-1:0]   vec_next;
	logic [POSITION_BITS-1:0] pos_next;
	logic [POSITION_BITS-1:0] start_calc;
	logic                     hit_now;
	logic                     is_text;
	logic                     is_restart;
	logic                     stall;
	store_wr_t                store_wr;

	// Register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);
	assign prdata = (paddr[2] == REG_PATTERN_LENGTH)
		? {{(APB_DATA_BITS - LEN_BITS){1'b0}}, len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_BITS'(1);
		end else if (cfg_wr) begin
			len_q <= pwdata[LEN_BITS-1:0];
		end
	end

	// Clamp the length into the lane range
	always_comb begin
		if (len_q == '0) begin
			act_len = LEN_BITS'(1);
		end else if (len_q > LEN_BITS'(PATTERN_MAX)) begin
			act_len = LEN_BITS'(PATTERN_MAX);
		end else begin
			act_len = len_q;
		end
	end

	// Hold a text item only while the result register is full and not taken
	assign is_text    = s1_valid && (s1_mode == MODE_TEXT);
	assign is_restart = s1_valid && (s1_mode == MODE_RESTART);
	assign stall      = is_text && m_valid_q && !m_tready;
	assign s_tready   = !stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!stall) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			s1_mode  <= s_tuser[MODE_BITS-1:0];
			s1_slot  <= s_tdata[SLOT_BITS-1:0];
			s1_value <= s_tdata[SLOT_BITS +: CHAR_BITS];
		end
	end

	// Pattern store and lane compares
	assign store_wr.en   = s1_valid && (s1_mode == MODE_LOAD);
	assign store_wr.slot = s1_slot;
	assign store_wr.data = s1_value;

	sapm_pattern_store #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (store_wr),
		.text_byte  (s1_value),
		.act_len    (act_len),
		.match_mask (match_mask),
		.last_lane  (last_lane)
	);

	// Shift, seed and mask the vector; advance the position
	assign vec_next   = ((vec_q << 1) | VEC_ONE) & match_mask;
	assign pos_next   = pos_q + POS_ONE;
	assign hit_now    = |(vec_next & last_lane);
	assign start_calc = pos_next - POSITION_BITS'(act_len) + POS_ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_q   <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (is_restart) begin
			vec_q   <= '0;
			pos_q   <= '0;
			found_q <= 1'b0;
		end else if (is_text && !stall) begin
			vec_q <= vec_next;
			pos_q <= pos_next;
			if (hit_now) begin
				found_q <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (is_text && !stall) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_text && !stall) begin
			hit_q   <= hit_now;
			start_q <= hit_now ? OUT_POS_BITS'(start_calc) : '0;
			first_q <= hit_now && !found_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(M_TDATA_BITS - OUT_POS_BITS - 2){1'b0}}, first_q, start_q, hit_q};

	// A first hit is always a hit
	a_first_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (hit_q || !first_q))
		else $error("first_hit set without hit");

	// No start position without a hit
	a_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !hit_q) |-> (start_q == '0))
		else $error("start_position nonzero without hit");

	// A delivered hit marks the search as found
	a_found_set: assert property (@(posedge clk) disable iff (!arst_n)
		(is_text && !stall && hit_now && !is_restart) |=> found_q)
		else $error("found flag not set after hit");

	// A restart clears the vector, the position and the found flag
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		is_restart |=> (vec_q == '0 && pos_q == '0 && !found_q))
		else $error("restart did not clear search state");

	// Input is held back only by a full, untaken result register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_valid_q && !m_tready))
		else $error("input stalled without output backpressure");

endmodule
